// ===== sv/line_sensor_marker_detector_core_macros.svh =====
// Assertion macros shared by the line sensor marker detector RTL.
`ifndef LINE_SENSOR_MARKER_DETECTOR_CORE_MACROS_SVH
`define LINE_SENSOR_MARKER_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define LSMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define LSMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LSMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define LSMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/lsmd_pkg.sv =====
// Package with the types, constants and codes of the line sensor marker detector.
package lsmd_pkg;

   localparam int SENSOR_COUNT    = 8;
   localparam int SAMPLE_BITS     = 12;
   localparam int DIFF_COUNT      = SENSOR_COUNT - 1;
   localparam int EDGE_COUNT_BITS = $clog2(DIFF_COUNT + 1);

   localparam int THRESH_BITS     = 12;
   localparam int CONFIRM_BITS    = 4;
   localparam int MIN_EDGE_BITS   = 3;
   localparam int CSR_DATA_BITS   = 12;
   localparam int CSR_INDEX_BITS  = 2;

   localparam int STRONG_OUT_BITS = 3;
   localparam int MAX_STEP_BITS   = 12;
   localparam int EDGE_CMP_BITS   =
      (EDGE_COUNT_BITS > MIN_EDGE_BITS) ? EDGE_COUNT_BITS : MIN_EDGE_BITS;

   localparam logic [STRONG_OUT_BITS-1:0] STRONG_OUT_MAX = '1;

   localparam logic [THRESH_BITS-1:0]   EDGE_LOW_THRESHOLD_RESET = 12'd3300;
   localparam logic [CONFIRM_BITS-1:0]  CONFIRM_COUNT_RESET      = 4'd3;
   localparam logic [MIN_EDGE_BITS-1:0] MIN_STRONG_EDGES_RESET   = 3'd2;

   typedef logic [SAMPLE_BITS-1:0]                   sample_type;
   typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_array_type;
   typedef logic [DIFF_COUNT-1:0][SAMPLE_BITS-1:0]   diff_array_type;

   typedef enum logic [1:0] {
      EVENT_NONE = 2'd0,
      EVENT_STOP = 2'd1,
      EVENT_GO   = 2'd2
   } event_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EDGE_LOW_THRESHOLD = 2'd0,
      CSR_CONFIRM_COUNT      = 2'd1,
      CSR_MIN_STRONG_EDGES   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0]   edge_low_threshold;
      logic [CONFIRM_BITS-1:0]  confirm_count;
      logic [MIN_EDGE_BITS-1:0] min_strong_edges;
   } csr_type;

   typedef struct packed {
      logic [EDGE_COUNT_BITS-1:0] edge_count;
      sample_type                 max_step;
   } merge_result_type;

   typedef struct packed {
      logic hit;
      logic go;
   } decision_type;

   typedef struct packed {
      event_type event_res;
      logic      clear_pending;
   } confirm_type;

endpackage

// ===== sv/lsmd_lane.sv =====
// One lane: absolute difference of two neighbouring reflectance samples.
module lsmd_lane (
   input  lsmd_pkg::sample_type sample_a,
   input  lsmd_pkg::sample_type sample_b,
   output lsmd_pkg::sample_type diff
);

   always_comb begin
      if (sample_a >= sample_b) begin
         diff = sample_a - sample_b;
      end else begin
         diff = sample_b - sample_a;
      end
   end

endmodule

// ===== sv/lsmd_merge.sv =====
// Merging stage: maximum of the lane differences and the count of strong edges.
module lsmd_merge (
   input  logic                            clock,
   input  logic                            load,
   input  lsmd_pkg::diff_array_type        diff_in,
   output lsmd_pkg::merge_result_type      result
);

   lsmd_pkg::diff_array_type diff_ff;
   lsmd_pkg::sample_type     max_ff;
   lsmd_pkg::sample_type     max_in;
   lsmd_pkg::sample_type     half_max;
   logic [lsmd_pkg::EDGE_COUNT_BITS-1:0] count;

   always_comb begin
      max_in = '0;
      for (int i = 0; i < lsmd_pkg::DIFF_COUNT; i++) begin
         if (diff_in[i] > max_in) begin
            max_in = diff_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff <= diff_in;
         max_ff  <= max_in;
      end
   end

   // An edge is strong when it lies strictly above half the largest step, rounded down.
   assign half_max = max_ff >> 1;

   always_comb begin
      count = '0;
      for (int i = 0; i < lsmd_pkg::DIFF_COUNT; i++) begin
         if (diff_ff[i] > half_max) begin
            count = count + lsmd_pkg::EDGE_COUNT_BITS'(1);
         end
      end
   end

   assign result.edge_count = count;
   assign result.max_step   = max_ff;

endmodule

// ===== sv/lsmd_confirm.sv =====
// Hit counter that confirms a stop or go point after enough hits.
module lsmd_confirm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  lsmd_pkg::decision_type                decision,
   input  logic [lsmd_pkg::CONFIRM_BITS-1:0]     confirm_count,
   output lsmd_pkg::confirm_type                 result
);

   logic [lsmd_pkg::CONFIRM_BITS-1:0] hit_counter_ff;
   logic [lsmd_pkg::CONFIRM_BITS-1:0] hit_counter_in;
   logic [lsmd_pkg::CONFIRM_BITS-1:0] count_plus;

   assign count_plus = hit_counter_ff + lsmd_pkg::CONFIRM_BITS'(1);

   always_comb begin
      result.event_res    = lsmd_pkg::EVENT_NONE;
      result.clear_pending = 1'b1;
      hit_counter_in       = hit_counter_ff;
      if (decision.hit) begin
         if (count_plus >= confirm_count) begin
            result.event_res = decision.go ? lsmd_pkg::EVENT_GO : lsmd_pkg::EVENT_STOP;
            hit_counter_in   = '0;
         end else begin
            result.clear_pending = 1'b0;
            hit_counter_in       = count_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_counter_ff <= '0;
      end else if (fire) begin
         hit_counter_ff <= hit_counter_in;
      end
   end

endmodule

// ===== sv/line_sensor_marker_detector_core.sv =====
// Top level of the line sensor marker detector: handshakes, registers and pipeline.
//
// The detector takes one scan of eight samples per cycle while the result side
// does not stall and returns exactly one result per scan, which passes the first
// stage, the merging stage and the output register in turn. Seven lanes form the
// neighbour differences in the first stage, the merging stage registers their
// maximum and counts the strong edges, and the hit counter updates as the result
// enters the output register. Each stage holds its item only while the next is
// full and stalled, so up to three scans are in flight. The user must write the
// registers only while no scan is in flight; the block does not enforce it.
`include "line_sensor_marker_detector_core_macros.svh"

module line_sensor_marker_detector_core (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    csr_wr_en,
   input  logic [lsmd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lsmd_pkg::CSR_DATA_BITS-1:0]      csr_wdata,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_operation,
   input  lsmd_pkg::sample_type                    req_sample_0,
   input  lsmd_pkg::sample_type                    req_sample_1,
   input  lsmd_pkg::sample_type                    req_sample_2,
   input  lsmd_pkg::sample_type                    req_sample_3,
   input  lsmd_pkg::sample_type                    req_sample_4,
   input  lsmd_pkg::sample_type                    req_sample_5,
   input  lsmd_pkg::sample_type                    req_sample_6,
   input  lsmd_pkg::sample_type                    req_sample_7,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [1:0]                              rsp_event_res,
   output logic                                    rsp_clear_pending,
   output logic [lsmd_pkg::STRONG_OUT_BITS-1:0]    rsp_strong_edges,
   output logic [lsmd_pkg::MAX_STEP_BITS-1:0]      rsp_max_step
);

   lsmd_pkg::csr_type          csr_ff;
   lsmd_pkg::csr_type          csr_in;

   lsmd_pkg::sample_array_type samples;
   lsmd_pkg::diff_array_type   diff_comb;
   logic                       end_low;

   // Stage one: lane differences.
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   lsmd_pkg::diff_array_type   s1_diff_ff;
   logic                       s1_go_ff;
   logic                       s1_end_low_ff;

   // Stage two: merged maximum and strong edge count.
   logic                       s2_valid_ff;
   logic                       s2_valid_in;
   logic                       s2_go_ff;
   logic                       s2_end_low_ff;
   lsmd_pkg::merge_result_type merge_result;

   // Output register.
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [1:0]                 rsp_event_res_ff;
   logic                       rsp_clear_pending_ff;
   logic [lsmd_pkg::STRONG_OUT_BITS-1:0] rsp_strong_edges_ff;
   logic [lsmd_pkg::MAX_STEP_BITS-1:0]   rsp_max_step_ff;
   logic [lsmd_pkg::STRONG_OUT_BITS-1:0] strong_sat;

   logic                       s1_ready;
   logic                       s2_ready;
   logic                       out_ready;
   logic                       s1_load;
   logic                       s2_load;
   logic                       out_load;

   lsmd_pkg::decision_type     decision;
   lsmd_pkg::confirm_type      confirm_result;

   // Configuration registers.
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lsmd_pkg::CSR_EDGE_LOW_THRESHOLD: begin
               csr_in.edge_low_threshold = csr_wdata[lsmd_pkg::THRESH_BITS-1:0];
            end
            lsmd_pkg::CSR_CONFIRM_COUNT: begin
               csr_in.confirm_count = csr_wdata[lsmd_pkg::CONFIRM_BITS-1:0];
            end
            lsmd_pkg::CSR_MIN_STRONG_EDGES: begin
               csr_in.min_strong_edges = csr_wdata[lsmd_pkg::MIN_EDGE_BITS-1:0];
            end
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.edge_low_threshold <= lsmd_pkg::EDGE_LOW_THRESHOLD_RESET;
         csr_ff.confirm_count      <= lsmd_pkg::CONFIRM_COUNT_RESET;
         csr_ff.min_strong_edges   <= lsmd_pkg::MIN_STRONG_EDGES_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Flow control: a stage takes a new item when it is empty or its item moves on.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_load  = req_valid && s1_ready;
   assign s2_load  = s1_valid_ff && s2_ready;
   assign out_load = s2_valid_ff && out_ready;

   assign s1_valid_in  = s1_ready  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Lanes.
   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;
   assign samples[4] = req_sample_4;
   assign samples[5] = req_sample_5;
   assign samples[6] = req_sample_6;
   assign samples[7] = req_sample_7;

   for (genvar i = 0; i < lsmd_pkg::DIFF_COUNT; i++) begin : g_lane
      lsmd_lane u_lane (
         .sample_a (samples[i]),
         .sample_b (samples[i+1]),
         .diff     (diff_comb[i])
      );
   end

   assign end_low = (samples[0] < csr_ff.edge_low_threshold)
                 || (samples[lsmd_pkg::SENSOR_COUNT-1] < csr_ff.edge_low_threshold);

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_diff_ff    <= diff_comb;
         s1_go_ff      <= req_operation;
         s1_end_low_ff <= end_low;
      end
   end

   lsmd_merge u_merge (
      .clock   (clock),
      .load    (s2_load),
      .diff_in (s1_diff_ff),
      .result  (merge_result)
   );

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_go_ff      <= s1_go_ff;
         s2_end_low_ff <= s1_end_low_ff;
      end
   end

   // Hit decision and confirmation.
   always_comb begin
      decision.go  = s2_go_ff;
      decision.hit = (lsmd_pkg::EDGE_CMP_BITS'(merge_result.edge_count)
                      > lsmd_pkg::EDGE_CMP_BITS'(csr_ff.min_strong_edges))
                  || (s2_go_ff && s2_end_low_ff);
   end

   lsmd_confirm u_confirm (
      .clock         (clock),
      .reset         (reset),
      .fire          (out_load),
      .decision      (decision),
      .confirm_count (csr_ff.confirm_count),
      .result        (confirm_result)
   );

   always_comb begin
      if (lsmd_pkg::EDGE_CMP_BITS'(merge_result.edge_count)
          > lsmd_pkg::EDGE_CMP_BITS'(lsmd_pkg::STRONG_OUT_MAX)) begin
         strong_sat = lsmd_pkg::STRONG_OUT_MAX;
      end else begin
         strong_sat = lsmd_pkg::STRONG_OUT_BITS'(merge_result.edge_count);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_event_res_ff     <= confirm_result.event_res;
         rsp_clear_pending_ff <= confirm_result.clear_pending;
         rsp_strong_edges_ff  <= strong_sat;
         rsp_max_step_ff      <= lsmd_pkg::MAX_STEP_BITS'(merge_result.max_step);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_event_res_ff;
   assign rsp_clear_pending = rsp_clear_pending_ff;
   assign rsp_strong_edges  = rsp_strong_edges_ff;
   assign rsp_max_step      = rsp_max_step_ff;

   `LSMD_ASSERT_IMPLY(a_event_clears_pending, clock, reset, rsp_valid_ff && (rsp_event_res_ff != lsmd_pkg::EVENT_NONE), rsp_clear_pending_ff, "An event was delivered without clear_pending.")
   `LSMD_ASSERT_IMPLY(a_strong_needs_step, clock, reset, rsp_valid_ff && (rsp_strong_edges_ff != '0), rsp_max_step_ff != '0, "Strong edges were reported on a flat scan.")
   `LSMD_ASSERT_NEXT(a_merge_holds, clock, reset, s2_valid_ff && !out_ready, s2_valid_ff && $stable(merge_result), "The merging stage lost or changed a held item.")

endmodule
